FILE: design/idot_pkg.sv
// Shared constants and bit-search helpers for the id occupancy tracker.
// No dependencies; imported by every module of the block except idot_ram.
package idot_pkg;

  localparam int MAX_KEY  = 1023;
  localparam int ID_W     = 10;
  localparam int LOW_W    = 11;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int ROWS     = (MAX_KEY + 1) / WORD_W;
  localparam int ROW_W    = $clog2(ROWS);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [LOW_W-1:0] ALL_USED = LOW_W'(MAX_KEY + 1);

  typedef struct packed {
    logic load;
    logic look;
    logic scan;
    logic emit;
  } idot_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic scan_done;
  } idot_status_t;

  // Position of the lowest clear bit (meaningful only when one exists).
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  // Position of the highest set bit (meaningful only when one exists).
  function automatic logic [BIT_W-1:0] highest_one(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

FILE: design/idot_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module idot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/idot_ctrl.sv
// Sequencer for the id occupancy tracker: request intake, lookup, scan, result.
// Depends on idot_pkg for the command and status structs.
module idot_ctrl
  import idot_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  idot_status_t st,
  output idot_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_ok;

  assign emit_ok = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = st.scan_more ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.emit = emit_ok;
        if (emit_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result while the consumer stalls.
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: design/idot_dp.sv
// Datapath of the id occupancy tracker: bitmap RAM, row valid bits, id registers.
// Depends on idot_pkg and idot_ram.
module idot_dp
  import idot_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  idot_cmd_t        cmd,
  output idot_status_t     st,
  input  logic             in_req_type,
  input  logic [ID_W-1:0]  in_item_id,
  output logic             out_ok,
  output logic [LOW_W-1:0] out_lowest_free,
  output logic [ID_W-1:0]  out_highest_used
);

  logic              del_r;
  logic [ID_W-1:0]   id_r;
  logic [LOW_W-1:0]  low_r, low_nxt;
  logic [ID_W-1:0]   high_r, high_nxt;
  logic              ok_r, ok_nxt;
  logic [ROWS-1:0]   row_valid_r;
  logic [ROW_W-1:0]  scan_row_r, scan_row_nxt;
  logic              out_ok_r;
  logic [LOW_W-1:0]  out_low_r;
  logic [ID_W-1:0]   out_high_r;

  logic [ROW_W-1:0]  id_row, chk_row, rd_addr, look_next_row, scan_next_row;
  logic [BIT_W-1:0]  id_bit;
  logic [WORD_W-1:0] rd_data, word_q, onehot, wr_data, up_word, down_word;
  logic [WORD_W-1:0] mask_le, mask_lt;
  logic              wr_en, id_ok, cur_bit, add_new, del_hit, up_need, down_need;
  logic              has_free, has_set, scan_free, scan_set;

  assign id_row  = id_r[ID_W-1:BIT_W];
  assign id_bit  = id_r[BIT_W-1:0];
  assign chk_row = cmd.look ? id_row : scan_row_r;

  // Rows never written read as empty.
  assign word_q = row_valid_r[chk_row] ? rd_data : '0;

  // Id zero is not a valid id; every other 10-bit id is in range.
  assign id_ok   = (id_r != '0);
  assign onehot  = WORD_W'(1) << id_bit;
  assign cur_bit = word_q[id_bit];
  assign add_new = !del_r && id_ok && !cur_bit;
  assign del_hit = del_r && id_ok && cur_bit;
  assign ok_nxt  = id_ok && (!del_r || cur_bit);

  assign wr_en   = cmd.look && (add_new || del_hit);
  assign wr_data = add_new ? (word_q | onehot) : (word_q & ~onehot);

  assign up_need   = add_new && ({1'b0, id_r} == low_r);
  assign down_need = del_hit && (id_r == high_r);

  // In-word search above (add) or below (delete) the touched bit.
  assign mask_le   = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - id_bit);
  assign mask_lt   = onehot - WORD_W'(1);
  assign up_word   = wr_data | mask_le;
  assign down_word = wr_data & mask_lt;
  assign has_free  = (~up_word != '0);
  assign has_set   = (down_word != '0);

  assign scan_free = (~word_q != '0);
  assign scan_set  = (word_q != '0);

  assign look_next_row = del_r ? (id_row - ROW_W'(1)) : (id_row + ROW_W'(1));
  assign scan_next_row = del_r ? (scan_row_r - ROW_W'(1)) : (scan_row_r + ROW_W'(1));

  assign st.scan_more = (up_need && !has_free && (id_row != LAST_ROW)) ||
                        (down_need && !has_set && (id_row != '0));
  assign st.scan_done = del_r ? (scan_set || (scan_row_r == '0))
                              : (scan_free || (scan_row_r == LAST_ROW));

  always_comb begin
    if (cmd.load)      rd_addr = in_item_id[ID_W-1:BIT_W];
    else if (cmd.look) rd_addr = look_next_row;
    else               rd_addr = scan_next_row;
  end

  always_comb begin
    low_nxt      = low_r;
    high_nxt     = high_r;
    scan_row_nxt = scan_row_r;
    if (cmd.look) begin
      scan_row_nxt = look_next_row;
      if (up_need) begin
        if (has_free)                low_nxt = {1'b0, id_row, lowest_zero(up_word)};
        else if (id_row == LAST_ROW) low_nxt = ALL_USED;
      end
      if (add_new && (id_r > high_r)) high_nxt = id_r;
      if (del_hit && ({1'b0, id_r} < low_r)) low_nxt = {1'b0, id_r};
      if (down_need) begin
        if (has_set)            high_nxt = {id_row, highest_one(down_word)};
        else if (id_row == '0)  high_nxt = '0;
      end
    end else if (cmd.scan) begin
      scan_row_nxt = scan_next_row;
      if (!del_r) begin
        if (scan_free)                   low_nxt = {1'b0, scan_row_r, lowest_zero(word_q)};
        else if (scan_row_r == LAST_ROW) low_nxt = ALL_USED;
      end else begin
        if (scan_set)               high_nxt = {scan_row_r, highest_one(word_q)};
        else if (scan_row_r == '0)  high_nxt = '0;
      end
    end
  end

  idot_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(id_row),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= LOW_W'(1);
      high_r      <= '0;
      row_valid_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      if (wr_en) row_valid_r[id_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      del_r <= in_req_type;
      id_r  <= in_item_id;
    end
    if (cmd.look) ok_r <= ok_nxt;
    scan_row_r <= scan_row_nxt;
    if (cmd.emit) begin
      out_ok_r   <= ok_r;
      out_low_r  <= low_r;
      out_high_r <= high_r;
    end
  end

  assign out_ok           = out_ok_r;
  assign out_lowest_free  = out_low_r;
  assign out_highest_used = out_high_r;

endmodule

FILE: design/id_occupancy_tracker_top.sv
// Top level of the id occupancy tracker: controller, datapath and bitmap RAM.
// Depends on idot_pkg, idot_ctrl and idot_dp.
//
// Tracks which ids in 1..1023 are in use and reports, for every request, an ok
// flag, the lowest free id (1024 when all are used) and the highest used id
// (0 when none is used). One result comes back for each accepted request.
// The occupancy bitmap lives in a 32 x 32-bit RAM; each row has a valid bit
// that reset clears, so the block is ready right after reset with no clearing
// pass. Requests are handled one at a time, each through accept, bitmap word
// lookup and update, and result load. When an add fills the lowest free id or
// a delete frees the highest used id, a scan can come between lookup and result
// load; it reads one bitmap row per cycle through the single RAM read port, up
// to 31 rows beyond the touched one.
// The result sits in an output register, so a new request is taken while the
// previous result still waits on a stalled consumer.
module id_occupancy_tracker_top
  import idot_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [ID_W-1:0]  in_item_id,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_ok,
  output logic [LOW_W-1:0] out_lowest_free,
  output logic [ID_W-1:0]  out_highest_used
);

  idot_cmd_t    cmd;
  idot_status_t st;

  // Sequence each request through lookup, optional scan and result load.
  idot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold the bitmap, the lowest free and highest used ids, and the result.
  idot_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (in_req_type),
    .in_item_id      (in_item_id),
    .out_ok          (out_ok),
    .out_lowest_free (out_lowest_free),
    .out_highest_used(out_highest_used)
  );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for id_occupancy_tracker_top: directed table, then random requests.
// Depends on idot_pkg (widths, MAX_KEY, ALL_USED) and the id_occupancy_tracker_top RTL.
module testbench;
  import idot_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request kinds as carried on in_req_type.
  typedef enum logic {REQ_ADD = 1'b0, REQ_DEL = 1'b1} req_kind_e;

  // Receiver back-pressure styles, picked at random by the receiver process.
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_LONG} stall_mode_e;

  typedef struct packed {
    logic             ok;
    logic [LOW_W-1:0] lowest_free;
    logic [ID_W-1:0]  highest_used;
  } tracker_result_t;

  typedef struct packed {
    req_kind_e        kind;
    logic [ID_W-1:0]  id;
    logic             typed;   // want holds the result to check, else use the predictor
    tracker_result_t  want;
  } plan_row_t;

  localparam tracker_result_t NO_WANT = '0;
  localparam int PLAN_LEN  = 25;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  // Directed requests, starting from the empty map. Rows with typed set carry a
  // result that follows directly from the map contents at that point.
  plan_row_t directed_plan [PLAN_LEN] = '{
    //  kind     id         typed  ok     lowest   highest
    '{REQ_DEL, 10'd5,    1'b1, '{1'b0, 11'd1, 10'd0}},    // delete of unused id
    '{REQ_ADD, 10'd0,    1'b1, '{1'b0, 11'd1, 10'd0}},    // id zero ignored
    '{REQ_DEL, 10'd0,    1'b1, '{1'b0, 11'd1, 10'd0}},
    '{REQ_ADD, 10'd1,    1'b1, '{1'b1, 11'd2, 10'd1}},    // fills the lowest free id
    '{REQ_ADD, 10'd1023, 1'b1, '{1'b1, 11'd2, 10'd1023}}, // top id
    '{REQ_ADD, 10'd1023, 1'b1, '{1'b1, 11'd2, 10'd1023}}, // add of used id
    '{REQ_ADD, 10'd2,    1'b1, '{1'b1, 11'd3, 10'd1023}},
    '{REQ_ADD, 10'd3,    1'b0, NO_WANT},
    '{REQ_ADD, 10'd5,    1'b0, NO_WANT},
    '{REQ_ADD, 10'd4,    1'b0, NO_WANT},                   // in-word search skips over 5
    '{REQ_DEL, 10'd1023, 1'b0, NO_WANT},                   // full rescan down to 5
    '{REQ_DEL, 10'd1,    1'b0, NO_WANT},                   // lowest free drops to 1
    '{REQ_DEL, 10'd1,    1'b1, '{1'b0, 11'd1, 10'd5}},    // second delete fails
    '{REQ_DEL, 10'd5,    1'b0, NO_WANT},                   // highest steps down one
    '{REQ_ADD, 10'd512,  1'b0, NO_WANT},
    '{REQ_ADD, 10'd511,  1'b0, NO_WANT},
    '{REQ_ADD, 10'd682,  1'b0, NO_WANT},
    '{REQ_ADD, 10'd341,  1'b0, NO_WANT},
    '{REQ_DEL, 10'd682,  1'b0, NO_WANT},
    '{REQ_DEL, 10'd512,  1'b0, NO_WANT},
    '{REQ_DEL, 10'd511,  1'b0, NO_WANT},
    '{REQ_DEL, 10'd341,  1'b0, NO_WANT},
    '{REQ_DEL, 10'd2,    1'b0, NO_WANT},
    '{REQ_DEL, 10'd3,    1'b0, NO_WANT},
    '{REQ_DEL, 10'd4,    1'b1, '{1'b1, 11'd1, 10'd0}}     // map empty again
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_req_type = 1'b0;
  logic [ID_W-1:0]  in_item_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_ok;
  logic [LOW_W-1:0] out_lowest_free;
  logic [ID_W-1:0]  out_highest_used;

  // Predictor state: occupancy map and the two tracked registers.
  bit               id_in_use [0:MAX_KEY];
  logic [LOW_W-1:0] lowest_free_q = LOW_W'(1);
  logic [ID_W-1:0]  highest_used_q = '0;

  tracker_result_t  pending_results [$];
  int               error_count = 0;
  int               adds_sent = 0;
  int               dels_sent = 0;
  int               full_hits = 0;
  int               rescans = 0;
  int               burst_left = 1;
  int               idle_cycles = 0;
  bit               valid_q = 1'b0;
  logic [15:0]      stall_phase = '0;
  stall_mode_e      stall_mode = STALL_NONE;

  id_occupancy_tracker_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_item_id       (in_item_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_lowest_free  (out_lowest_free),
    .out_highest_used (out_highest_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the predicted occupancy and return the result it gives.
  function automatic tracker_result_t track_request(req_kind_e kind, logic [ID_W-1:0] id);
    tracker_result_t r;
    int probe;
    r.ok = 1'b0;
    if (id >= 1 && id <= MAX_KEY) begin
      if (kind == REQ_ADD) begin
        r.ok = 1'b1;
        if (!id_in_use[id]) begin
          id_in_use[id] = 1'b1;
          // Filling the lowest free id: walk up to the next hole.
          if (id == lowest_free_q) begin
            probe = id + 1;
            while (probe <= MAX_KEY && id_in_use[probe]) probe++;
            lowest_free_q = LOW_W'(probe);
          end
          if (id > highest_used_q) highest_used_q = id;
        end
      end else if (id_in_use[id]) begin
        r.ok = 1'b1;
        id_in_use[id] = 1'b0;
        if ({1'b0, id} < lowest_free_q) lowest_free_q = {1'b0, id};
        // Freeing the highest id: step down one, or search from the top.
        if (id == highest_used_q) begin
          if (id > 1 && id_in_use[id-1]) begin
            highest_used_q = id - ID_W'(1);
          end else begin
            probe = MAX_KEY;
            while (probe > 0 && !id_in_use[probe]) probe--;
            highest_used_q = ID_W'(probe);
            rescans++;
          end
        end
      end
    end
    r.lowest_free = lowest_free_q;
    r.highest_used = highest_used_q;
    return r;
  endfunction

  // Pick an id that tends to hit the interesting spots of the current map.
  function automatic logic [ID_W-1:0] choose_id(req_kind_e kind);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 7) begin
      // Noise: id zero for adds, the id just below the lowest hole for deletes.
      return (kind == REQ_ADD) ? '0 : ID_W'(lowest_free_q - 1);
    end else if (roll >= 8) begin
      return ID_W'($urandom_range(0, MAX_KEY));
    end else if (roll >= 4) begin
      return ID_W'($urandom_range(1, 64));
    end else if (kind == REQ_ADD) begin
      return (lowest_free_q <= MAX_KEY) ? lowest_free_q[ID_W-1:0]
                                        : ID_W'($urandom_range(1, MAX_KEY));
    end else begin
      return (highest_used_q != 0) ? highest_used_q : ID_W'($urandom_range(1, 64));
    end
  endfunction

  // Drop valid if it is currently driven high.
  task automatic idle_sender();
    if (valid_q) begin
      in_valid <= 1'b0;
      valid_q = 1'b0;
    end
  endtask

  // Advance the burst count; between bursts, hold off for a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
      if (gap > 0) begin
        idle_sender();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Present one request, hold it until accepted, then log its expected result.
  task automatic send_request(req_kind_e kind, logic [ID_W-1:0] id, bit typed,
                              tracker_result_t want);
    tracker_result_t predicted;
    if (!valid_q) in_valid <= 1'b1;
    valid_q = 1'b1;
    in_req_type <= kind;
    in_item_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = track_request(kind, id);
    pending_results.push_back(typed ? want : predicted);
    if (predicted.lowest_free == ALL_USED) full_hits++;
    if (kind == REQ_ADD) adds_sent++;
    else dels_sent++;
    pace_sender();
  endtask

  // Random mix; del_pct sets the share of deletes.
  task automatic run_mix(int count, int del_pct);
    req_kind_e kind;
    for (int n = 0; n < count; n++) begin
      kind = ($urandom_range(0, 99) < del_pct) ? REQ_DEL : REQ_ADD;
      send_request(kind, choose_id(kind), 1'b0, NO_WANT);
    end
  endtask

  // Hold the request channel idle until every result has come back.
  task automatic drain_results();
    idle_sender();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall on its own schedule, picking a style whenever stall_phase[7:0] wraps to zero.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 16'd1;
    if (stall_phase[7:0] == 8'd0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= (stall_phase[2:0] < 3'd5);
      default:     out_stall <= (stall_phase[5:4] == 2'b00);
    endcase
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    tracker_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: ok=%0d lowest_free=%0d highest_used=%0d",
               out_ok, out_lowest_free, out_highest_used);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          error_count++;
        end
        if (out_lowest_free !== want.lowest_free) begin
          $error("lowest_free: expected %0d, got %0d", want.lowest_free, out_lowest_free);
          error_count++;
        end
        if (out_highest_used !== want.highest_used) begin
          $error("highest_used: expected %0d, got %0d", want.highest_used, out_highest_used);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("testbench: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [ID_W-1:0] holes [$];
    logic [ID_W-1:0] swap_id;
    logic [ID_W-1:0] poke_id;
    int pick;

    foreach (id_in_use[i]) id_in_use[i] = 1'b0;

    // Hold reset, then release it for good.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].kind, directed_plan[i].id, directed_plan[i].typed,
                   directed_plan[i].want);
    end

    // Random mix, add-leaning, mostly around the low ids, the lowest free id and the highest used id.
    run_mix(150, 35);

    // Pause the sender completely until the block has caught up.
    drain_results();

    // Fill every remaining hole in shuffled order until the map is full.
    for (int id = 1; id <= MAX_KEY; id++) begin
      if (!id_in_use[id]) holes.push_back(ID_W'(id));
    end
    for (int i = holes.size() - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      swap_id = holes[i];
      holes[i] = holes[pick];
      holes[pick] = swap_id;
    end
    foreach (holes[i]) send_request(REQ_ADD, holes[i], 1'b0, NO_WANT);

    // With the map full: re-add a used id, free it, and fill it again.
    for (int n = 0; n < 10; n++) begin
      poke_id = ID_W'($urandom_range(1, MAX_KEY));
      send_request(REQ_ADD, poke_id, 1'b0, NO_WANT);
      send_request(REQ_DEL, poke_id, 1'b0, NO_WANT);
      send_request(REQ_ADD, poke_id, 1'b0, NO_WANT);
    end

    // Delete-leaning mix to drive the highest-used search from a dense map.
    run_mix(150, 65);

    // Wait for the last results, then let the block settle.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("covered %0d adds and %0d deletes; %0d results reported a full map,",
             adds_sent, dels_sent, full_hits);
    $display("and the highest used id was searched from the top %0d times", rescans);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
